// ===== sv/ptzenc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptzenc_pkg
// shared types and constants of the joystick to camera frame encoder
// ----------------------------------------------------------------------------
package ptzenc_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] SYNC_BYTE = 8'hA0;
    localparam logic [7:0] STOP_BYTE = 8'hAF;

    localparam logic [7:0] MSG_CONTROL  = 8'd2;
    localparam logic [7:0] MSG_PROGRAM  = 8'd3;
    localparam logic [7:0] SUB_MENU     = 8'd0;
    localparam logic [7:0] SUB_NAVIGATE = 8'd1;
    localparam logic [7:0] SUB_PRESET   = 8'd2;
    localparam logic [7:0] SUB_POWER    = 8'd3;

    localparam logic [IDX_W-1:0] IDX_SYNC = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_ADDR = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_D0   = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_D1   = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_D2   = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_D3   = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_STOP = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_CKS  = IDX_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic [7:0] message_type;
        logic [7:0] field_one;
        logic [7:0] field_two;
        logic [7:0] field_three;
        logic [7:0] field_four;
    } ptzenc_msg_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       power_cycle;
        logic       last_of_run;
    } ptzenc_result_t;

    // four data bytes of one frame, entry 0 is frame byte 2
    typedef logic [3:0][7:0] ptzenc_data_t;

    typedef struct packed {
        logic         power;
        logic         two_frames;
        ptzenc_data_t first;
        ptzenc_data_t second;
    } ptzenc_job_t;

    typedef struct packed {
        logic        push;
        ptzenc_job_t job;
    } ptzenc_push_t;

endpackage

// ===== sv/ptzenc_front.sv =====
// ----------------------------------------------------------------------------
// ptzenc_front
// accepts robot messages, classifies them and builds frame jobs
// ----------------------------------------------------------------------------
module ptzenc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  q_full,
    input  ptzenc_pkg::ptzenc_msg_t message,
    output ptzenc_pkg::ptzenc_push_t push
);
    import ptzenc_pkg::*;

    localparam logic [2:0] DEAD_NONE = 3'd0;
    localparam logic [2:0] DEAD_JOG  = 3'd5;

    logic homing_reg;
    logic homing_next;
    logic accept;
    logic has_job;
    ptzenc_job_t job;

    function automatic logic [6:0] magnitude(input logic [7:0] v);
        magnitude = v[7] ? v[6:0] : ~v[6:0];
    endfunction

    function automatic logic [7:0] speed_of(input logic [7:0] v, input logic [2:0] dead);
        logic [12:0] p;
        logic [5:0]  s;
        // divide by three through the reciprocal 43/128
        p = {6'd0, magnitude(v)} * 13'd43;
        s = p[12:7];
        if (s < {3'd0, dead})
        begin
            s = 6'd0;
        end
        if (s > 6'd32)
        begin
            s = 6'd32;
        end
        if (s < 6'd3)
        begin
            s = 6'd0;
        end
        speed_of = {2'd0, s};
    endfunction

    function automatic ptzenc_data_t make_data(input logic [7:0] b1, input logic [7:0] b2,
                                               input logic [7:0] b3, input logic [7:0] b4);
        ptzenc_data_t d;
        d[0] = b1;
        d[1] = b2;
        d[2] = b3;
        d[3] = b4;
        make_data = d;
    endfunction

    function automatic ptzenc_data_t move_data(input logic [7:0] h, input logic [7:0] v,
                                               input logic [7:0] buttons,
                                               input logic [2:0] dead);
        logic [7:0] d;
        d = 8'h00;
        d = d | ((h <= 8'd127) ? 8'h02 : 8'h04);
        d = d | (v[7] ? 8'h08 : 8'h10);
        if (buttons[7])
        begin
            d = d | 8'h20;
        end
        else if (buttons[6])
        begin
            d = d | 8'h40;
        end
        move_data = make_data(8'h00, d, speed_of(h, dead), speed_of(v, dead));
    endfunction

    function automatic ptzenc_data_t nav_data(input logic [7:0] h, input logic [7:0] v,
                                              input logic [7:0] buttons);
        logic [7:0] d;
        d = 8'h00;
        if (h > 8'd167)
        begin
            d = d | 8'h02;
        end
        else if (h < 8'd87)
        begin
            d = d | 8'h04;
        end
        if (v > 8'd167)
        begin
            d = d | 8'h10;
        end
        else if (v < 8'd87)
        begin
            d = d | 8'h08;
        end
        if (buttons[7])
        begin
            nav_data = make_data(8'h08, 8'h00, 8'h00, 8'h00);
        end
        else if (buttons[6])
        begin
            nav_data = make_data(8'h04, 8'h00, 8'h00, 8'h00);
        end
        else if (magnitude(h) > 7'd50)
        begin
            nav_data = make_data(8'h00, d, 8'h10, 8'h00);
        end
        else if (magnitude(v) > 7'd50)
        begin
            nav_data = make_data(8'h00, d, 8'h00, 8'h10);
        end
        else
        begin
            nav_data = make_data(8'h00, 8'h00, 8'h00, 8'h00);
        end
    endfunction

    assign accept = in_valid && !q_full;

    always_comb
    begin
        has_job         = 1'b0;
        homing_next     = homing_reg;
        job.power       = 1'b0;
        job.two_frames  = 1'b0;
        job.first       = make_data(8'h00, 8'h00, 8'h00, 8'h00);
        job.second      = make_data(8'h00, 8'h07, 8'h00, 8'h01);
        if (message.message_type == MSG_CONTROL)
        begin
            has_job = 1'b1;
            if (message.field_three[5])
            begin
                // home request, stop frame first unless already homing
                homing_next = 1'b1;
                if (homing_reg)
                begin
                    job.first = make_data(8'h00, 8'h07, 8'h00, 8'h01);
                end
                else
                begin
                    job.two_frames = 1'b1;
                end
            end
            else
            begin
                homing_next = 1'b0;
                job.first   = move_data(message.field_one, message.field_two,
                                        message.field_three, DEAD_NONE);
            end
        end
        else if (message.message_type == MSG_PROGRAM)
        begin
            case (message.field_one)
                SUB_MENU:
                begin
                    has_job   = 1'b1;
                    job.first = make_data(8'h00, 8'h03, 8'h00, 8'd95);
                end
                SUB_NAVIGATE:
                begin
                    has_job   = 1'b1;
                    job.first = nav_data(message.field_two, message.field_three,
                                         message.field_four);
                end
                SUB_PRESET:
                begin
                    if (message.field_four[3])
                    begin
                        has_job   = 1'b1;
                        job.first = move_data(message.field_two, message.field_three,
                                              message.field_four, DEAD_JOG);
                    end
                    else if (message.field_four[5])
                    begin
                        has_job        = 1'b1;
                        job.two_frames = 1'b1;
                        job.first      = make_data(8'h00, 8'h03, 8'h00, 8'h01);
                        job.second     = make_data(8'h04, 8'h00, 8'h00, 8'h00);
                    end
                    else if (message.field_four[4])
                    begin
                        has_job   = 1'b1;
                        job.first = make_data(8'h00, 8'h07, 8'h00, 8'h01);
                    end
                end
                SUB_POWER:
                begin
                    has_job   = 1'b1;
                    job.power = 1'b1;
                end
                default:
                begin
                    has_job = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_reg <= 1'b0;
        end
        else if (accept)
        begin
            homing_reg <= homing_next;
        end
    end

    assign push.push = accept && has_job;
    assign push.job  = job;

endmodule

// ===== sv/ptzenc_queue.sv =====
// ----------------------------------------------------------------------------
// ptzenc_queue
// two-entry job queue between the front and back parts
// ----------------------------------------------------------------------------
module ptzenc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ptzenc_pkg::ptzenc_push_t push,
    input  logic                    pop,
    output logic                    full,
    output logic                    not_empty,
    output ptzenc_pkg::ptzenc_job_t  head
);
    import ptzenc_pkg::*;

    ptzenc_job_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push.push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push.push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/ptzenc_back.sv =====
// ----------------------------------------------------------------------------
// ptzenc_back
// serializes frame jobs into byte results through an output register
// ----------------------------------------------------------------------------
module ptzenc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                address,
    input  logic                      q_not_empty,
    input  ptzenc_pkg::ptzenc_job_t    q_head,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ptzenc_pkg::ptzenc_result_t result
);
    import ptzenc_pkg::*;

    ptzenc_job_t      job_reg;
    logic             busy_reg;
    logic             sel_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    ptzenc_result_t   out_reg;

    ptzenc_data_t   data;
    ptzenc_result_t cur;
    logic           advance;
    logic [7:0]     checksum;

    assign data     = sel_reg ? job_reg.second : job_reg.first;
    assign checksum = SYNC_BYTE ^ STOP_BYTE ^ address ^ data[0] ^ data[1] ^ data[2] ^ data[3];

    always_comb
    begin
        cur.byte_valid  = !job_reg.power;
        cur.power_cycle = job_reg.power;
        cur.frame_end   = !job_reg.power && (idx_reg == IDX_CKS);
        cur.last_of_run = job_reg.power ||
                          ((idx_reg == IDX_CKS) && (!job_reg.two_frames || sel_reg));
        case (idx_reg)
            IDX_SYNC: cur.tx_byte = SYNC_BYTE;
            IDX_ADDR: cur.tx_byte = address;
            IDX_D0:   cur.tx_byte = data[0];
            IDX_D1:   cur.tx_byte = data[1];
            IDX_D2:   cur.tx_byte = data[2];
            IDX_D3:   cur.tx_byte = data[3];
            IDX_STOP: cur.tx_byte = STOP_BYTE;
            IDX_CKS:  cur.tx_byte = checksum;
            default:  cur.tx_byte = 8'h00;
        endcase
        if (job_reg.power)
        begin
            cur.tx_byte = 8'h00;
        end
    end

    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign pop     = q_not_empty && (!busy_reg || (advance && cur.last_of_run));

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_head;
        end
        if (advance)
        begin
            out_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sel_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                busy_reg <= 1'b1;
                sel_reg  <= 1'b0;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                if (cur.last_of_run)
                begin
                    busy_reg <= 1'b0;
                end
                else if (idx_reg == IDX_CKS)
                begin
                    sel_reg <= 1'b1;
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

// ===== sv/joystick_to_ptz_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// joystick_to_ptz_frame_encoder
// turns robot messages into 8-byte camera frames, one byte per transfer
// ----------------------------------------------------------------------------
// when idle a job goes through the queue, job_reg and out_reg to the output
// throughput: one result per cycle from the byte serializer when not stalled;
//   an item is 8 bytes for one frame, 16 for two, a single result for power
// a two-entry job queue lets new items enter while earlier frames drain
// reset: asynchronous, clears homing flag, camera address, queue and output
module joystick_to_ptz_frame_encoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [7:0]                cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  ptzenc_pkg::ptzenc_msg_t    message,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ptzenc_pkg::ptzenc_result_t result
);
    import ptzenc_pkg::*;

    logic [7:0]   address_reg;
    ptzenc_push_t push;
    ptzenc_job_t  q_head;
    logic         q_full;
    logic         q_not_empty;
    logic         pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            address_reg <= cfg_wdata;
        end
    end

    assign in_stall = q_full;

    ptzenc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .q_full   (q_full),
        .message  (message),
        .push     (push)
    );

    ptzenc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ptzenc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .address     (address_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

endmodule

// ===== sv/ptzenc_checker.sv =====
// ----------------------------------------------------------------------------
// ptzenc_checker
// port-level checks of the frame encoder output stream
// ----------------------------------------------------------------------------
module ptzenc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input ptzenc_pkg::ptzenc_result_t result
);
    import ptzenc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result))
        else $error("output payload changed while stalled");

    a_power_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result.power_cycle |->
            !result.byte_valid && !result.frame_end && result.last_of_run
            && (result.tx_byte == 8'h00))
        else $error("power cycle result malformed");

    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result.byte_valid && result.last_of_run |-> result.frame_end)
        else $error("run ended inside a frame");

    a_sync_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && result.frame_end ##1 out_valid && result.byte_valid
            |-> result.tx_byte == SYNC_BYTE)
        else $error("frame did not start with sync byte");

endmodule

bind joystick_to_ptz_frame_encoder ptzenc_checker u_ptzenc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
);

// ===== tb/sv/tb_joystick_to_ptz_frame_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_to_ptz_frame_encoder
// Drives robot messages into the camera frame encoder. Each transfer is
// predicted into the expected frame bytes and power cycle requests, and every
// output transfer is checked field by field. The run starts with hand-picked
// messages and then switches the camera address between random phases.
// Idle and stall bursts on both sides vary by phase.
// ----------------------------------------------------------------------------
module tb_joystick_to_ptz_frame_encoder;

    import ptzenc_pkg::*;

    localparam int LIMIT_CYCLES = 300000;

    localparam logic [7:0] BTN_ZOOM_IN  = 8'h80;
    localparam logic [7:0] BTN_ZOOM_OUT = 8'h40;
    localparam logic [7:0] BTN_HOME     = 8'h20;
    localparam logic [7:0] BTN_STORE    = 8'h20;
    localparam logic [7:0] BTN_RECALL   = 8'h10;
    localparam logic [7:0] BTN_JOG      = 8'h08;

    localparam logic [7:0] DIR_RIGHT = 8'h02;
    localparam logic [7:0] DIR_LEFT  = 8'h04;
    localparam logic [7:0] DIR_UP    = 8'h08;
    localparam logic [7:0] DIR_DOWN  = 8'h10;
    localparam logic [7:0] ZOOM_TELE = 8'h20;
    localparam logic [7:0] ZOOM_WIDE = 8'h40;

    localparam logic [7:0] CMD_SET_PRESET  = 8'h03;
    localparam logic [7:0] CMD_GOTO_PRESET = 8'h07;
    localparam logic [7:0] PRESET_ONE      = 8'h01;
    localparam logic [7:0] MENU_PRESET     = 8'd95;
    localparam logic [7:0] NAV_SELECT      = 8'h08;
    localparam logic [7:0] NAV_BACK        = 8'h04;
    localparam logic [7:0] NAV_SPEED       = 8'h10;

    localparam int NAV_HIGH  = 167;
    localparam int NAV_LOW   = 87;
    localparam int NAV_MAG   = 50;
    localparam int SPEED_MAX = 32;
    localparam int SPEED_MIN = 3;
    localparam int JOG_DEAD  = 5;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [7:0]     cfg_wdata = 8'h00;
    logic           in_valid = 1'b0;
    logic           in_stall;
    ptzenc_msg_t    message = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    ptzenc_result_t result;

    ptzenc_msg_t    msg_backlog[$];
    ptzenc_result_t bytes_due[$];
    ptzenc_result_t run_buf[$];

    logic [7:0] cam_addr = 8'h00;
    logic       homing_set = 1'b0;
    int         idle_pct = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         gap_left = 0;
    int         stall_left = 0;

    joystick_to_ptz_frame_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .message   (message),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int stick_mag(input logic [7:0] v);
        return (v >= 8'd128) ? int'(v) - 128 : 127 - int'(v);
    endfunction

    function automatic logic [7:0] axis_speed(input logic [7:0] v, input int dead);
        int s;
        s = stick_mag(v) / 3;
        if (s < dead)
            s = 0;
        if (s > SPEED_MAX)
            s = SPEED_MAX;
        if (s < SPEED_MIN)
            s = 0;
        return 8'(s);
    endfunction

    function automatic void push_frame(input logic [7:0] c1, input logic [7:0] c2,
                                       input logic [7:0] d1, input logic [7:0] d2);
        logic [7:0]     f[FRAME_BYTES];
        logic [7:0]     cks;
        ptzenc_result_t r;
        int             i;
        f = '{SYNC_BYTE, cam_addr, c1, c2, d1, d2, STOP_BYTE, 8'h00};
        cks = 8'h00;
        for (i = 0; i < FRAME_BYTES - 1; i++)
            cks ^= f[i];
        f[FRAME_BYTES - 1] = cks;
        for (i = 0; i < FRAME_BYTES; i++)
        begin
            r = '0;
            r.tx_byte    = f[i];
            r.byte_valid = 1'b1;
            r.frame_end  = (i == FRAME_BYTES - 1);
            run_buf.push_back(r);
        end
    endfunction

    function automatic void push_move(input logic [7:0] h, input logic [7:0] v,
                                      input logic [7:0] btn, input int dead);
        logic [7:0] d;
        d = (h <= 8'd127) ? DIR_RIGHT : DIR_LEFT;
        d |= (v >= 8'd128) ? DIR_UP : DIR_DOWN;
        if (btn & BTN_ZOOM_IN)
            d |= ZOOM_TELE;
        else if (btn & BTN_ZOOM_OUT)
            d |= ZOOM_WIDE;
        push_frame(8'h00, d, axis_speed(h, dead), axis_speed(v, dead));
    endfunction

    function automatic void predict_frames(input ptzenc_msg_t m);
        ptzenc_result_t r;
        logic [7:0]     d;
        run_buf.delete();
        case (m.message_type)
            MSG_CONTROL:
            begin
                if (m.field_three & BTN_HOME)
                begin
                    if (!homing_set)
                        push_frame(8'h00, 8'h00, 8'h00, 8'h00);
                    push_frame(8'h00, CMD_GOTO_PRESET, 8'h00, PRESET_ONE);
                    homing_set = 1'b1;
                end
                else
                begin
                    homing_set = 1'b0;
                    push_move(m.field_one, m.field_two, m.field_three, 0);
                end
            end
            MSG_PROGRAM:
            begin
                case (m.field_one)
                    SUB_MENU:
                        push_frame(8'h00, CMD_SET_PRESET, 8'h00, MENU_PRESET);
                    SUB_NAVIGATE:
                    begin
                        d = 8'h00;
                        if (m.field_two > NAV_HIGH)
                            d |= DIR_RIGHT;
                        else if (m.field_two < NAV_LOW)
                            d |= DIR_LEFT;
                        if (m.field_three > NAV_HIGH)
                            d |= DIR_DOWN;
                        else if (m.field_three < NAV_LOW)
                            d |= DIR_UP;
                        if (m.field_four & BTN_ZOOM_IN)
                            push_frame(NAV_SELECT, 8'h00, 8'h00, 8'h00);
                        else if (m.field_four & BTN_ZOOM_OUT)
                            push_frame(NAV_BACK, 8'h00, 8'h00, 8'h00);
                        else if (stick_mag(m.field_two) > NAV_MAG)
                            push_frame(8'h00, d, NAV_SPEED, 8'h00);
                        else if (stick_mag(m.field_three) > NAV_MAG)
                            push_frame(8'h00, d, 8'h00, NAV_SPEED);
                        else
                            push_frame(8'h00, 8'h00, 8'h00, 8'h00);
                    end
                    SUB_PRESET:
                    begin
                        if (m.field_four & BTN_JOG)
                            push_move(m.field_two, m.field_three, m.field_four, JOG_DEAD);
                        else if (m.field_four & BTN_STORE)
                        begin
                            push_frame(8'h00, CMD_SET_PRESET, 8'h00, PRESET_ONE);
                            push_frame(NAV_BACK, 8'h00, 8'h00, 8'h00);
                        end
                        else if (m.field_four & BTN_RECALL)
                            push_frame(8'h00, CMD_GOTO_PRESET, 8'h00, PRESET_ONE);
                    end
                    SUB_POWER:
                    begin
                        r = '0;
                        r.power_cycle = 1'b1;
                        run_buf.push_back(r);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (run_buf.size() > 0)
        begin
            r = run_buf.pop_back();
            r.last_of_run = 1'b1;
            run_buf.push_back(r);
        end
        foreach (run_buf[i])
            bytes_due.push_back(run_buf[i]);
    endfunction

    function automatic void check_result(input ptzenc_result_t got);
        ptzenc_result_t want;
        if (bytes_due.size() == 0)
        begin
            $error("unexpected transfer: tx_byte %h", got.tx_byte);
            fail_count++;
            return;
        end
        want = bytes_due.pop_front();
        if (got.tx_byte !== want.tx_byte)
        begin
            $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
            fail_count++;
        end
        if (got.byte_valid !== want.byte_valid)
        begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
            fail_count++;
        end
        if (got.frame_end !== want.frame_end)
        begin
            $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
            fail_count++;
        end
        if (got.power_cycle !== want.power_cycle)
        begin
            $error("power_cycle: expected %b, got %b", want.power_cycle, got.power_cycle);
            fail_count++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
            fail_count++;
        end
    endfunction

    // sender side
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic        nxt_valid;
        ptzenc_msg_t nxt_msg;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            message  <= '0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_msg   = message;
            if (in_valid && !in_stall)
            begin
                predict_frames(message);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (msg_backlog.size() > 0)
                begin
                    nxt_msg   = msg_backlog.pop_front();
                    nxt_valid = 1'b1;
                    if (idle_pct > 0 && $urandom_range(99) < idle_pct)
                        gap_left = $urandom_range(1, 8);
                end
            end
            in_valid <= nxt_valid;
            message  <= nxt_msg;
        end
    end

    // receiver side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_result(result);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_pct > 0 && $urandom_range(99) < idle_pct / 3)
            begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic ptzenc_msg_t pack_msg(input logic [7:0] t, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] c,
                                             input logic [7:0] d);
        ptzenc_msg_t m;
        m.message_type = t;
        m.field_one    = a;
        m.field_two    = b;
        m.field_three  = c;
        m.field_four   = d;
        return m;
    endfunction

    function automatic ptzenc_msg_t random_msg();
        ptzenc_msg_t m;
        int          pick;
        m = pack_msg(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            m.message_type = MSG_CONTROL;
            m.field_three[5] = ($urandom_range(9) < 3);
        end
        else if (pick < 85)
        begin
            m.message_type = MSG_PROGRAM;
            if ($urandom_range(9) != 0)
                m.field_one = 8'($urandom_range(3));
        end
        return m;
    endfunction

    task automatic wait_drained();
        do
            @(posedge clk);
        while (msg_backlog.size() != 0 || in_valid || bytes_due.size() != 0);
    endtask

    task automatic run_phase(input logic [7:0] addr, input int n_items, input int pct);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        cam_addr = addr;
        idle_pct = pct;
        repeat (n_items)
            msg_backlog.push_back(random_msg());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd0, 8'd0, 8'h00, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd255, 8'd255, BTN_ZOOM_IN, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd127, 8'd128, BTN_ZOOM_OUT, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd128, 8'd127, 8'hC0, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd134, 8'd118, 8'h00, 8'h00));
        // home from moving, home again, then a programming message in between
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd90, 8'd200, BTN_HOME, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd0, 8'd0, BTN_HOME, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_MENU, 8'd0, 8'd0, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd255, 8'd255, 8'hFF, 8'hFF));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd60, 8'd60, 8'h00, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_CONTROL, 8'd0, 8'd0, BTN_HOME, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_NAVIGATE, 8'd128, 8'd128, 8'hC0));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_NAVIGATE, 8'd128, 8'd128, 8'h40));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_NAVIGATE, 8'd255, 8'd128, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_NAVIGATE, 8'd128, 8'd0, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_NAVIGATE, 8'd100, 8'd150, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_NAVIGATE, 8'd0, 8'd255, 8'h00));
        // jog right at and just below the wider deadband
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_PRESET, 8'd143, 8'd112, BTN_JOG));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_PRESET, 8'd140, 8'd115, 8'h88));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_PRESET, 8'd0, 8'd255, BTN_STORE));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_PRESET, 8'd0, 8'd0, BTN_RECALL));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_PRESET, 8'd255, 8'd255, 8'h47));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, SUB_POWER, 8'd0, 8'd0, 8'h00));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, 8'd4, 8'd1, 8'd2, 8'h80));
        msg_backlog.push_back(pack_msg(MSG_PROGRAM, 8'd255, 8'd255, 8'd255, 8'hFF));
        msg_backlog.push_back(pack_msg(8'd0, 8'd0, 8'd0, 8'h20, 8'h00));
        msg_backlog.push_back(pack_msg(8'd255, 8'd255, 8'd255, 8'hFF, 8'hFF));

        run_phase(8'hFF, 45, 0);
        run_phase(8'($urandom_range(1, 254)), 45, 35);
        run_phase(8'h00, 45, 65);
        run_phase(8'($urandom_range(1, 254)), 45, 0);

        wait_drained();
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== joystick_to_ptz_frame_encoder.f =====
sv/ptzenc_pkg.sv
sv/ptzenc_front.sv
sv/ptzenc_queue.sv
sv/ptzenc_back.sv
sv/joystick_to_ptz_frame_encoder.sv
sv/ptzenc_checker.sv
tb/sv/tb_joystick_to_ptz_frame_encoder.sv
